>>> src/pas_pkg.sv
// ----------------------------------------------------------------------------
// pas_pkg: shared definitions for the pair association score core
// Field widths, fixed-point constants and configuration register indexes.
// ----------------------------------------------------------------------------
package pas_pkg;

  localparam int unsigned PosW   = 24;
  localparam int unsigned KindW  = 4;
  localparam int unsigned SubW   = 5;
  localparam int unsigned ProbW  = 17;
  localparam int unsigned ScoreW = 32;
  localparam int unsigned LimitW = 20;
  localparam int unsigned ScaleW = 16;
  localparam int unsigned CfgW   = 32;
  localparam int unsigned CfgIdxW = 2;

  // sum of squares is 49 bits, padded to an even radicand
  localparam int unsigned RadW  = 50;
  localparam int unsigned RootW = RadW / 2;

  // factor: Q0.32 for the same-subkind path, Q.24 for the mixed path
  localparam int unsigned FactW = 33;
  // sideband through the square root: factor plus shift select
  localparam int unsigned SideW = FactW + 1;

  localparam logic [ProbW-1:0] ProbOne = 17'd65536;

  localparam logic [LimitW-1:0] LimitRst = 20'd2560;
  localparam logic [ScoreW-1:0] MinRst   = 32'd0;
  localparam logic              TceRst   = 1'b1;
  localparam logic [ScaleW-1:0] ScaleRst = 16'd256;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LIMIT = 2'd0,
    CFG_MIN   = 2'd1,
    CFG_TCE   = 2'd2,
    CFG_SCALE = 2'd3
  } cfg_idx_e;

endpackage

>>> src/pas_isqrt.sv
// ----------------------------------------------------------------------------
// pas_isqrt: pipelined integer square root
// One result bit per stage, floor(sqrt(rad)), with a sideband carried along.
// ----------------------------------------------------------------------------
module pas_isqrt
  import pas_pkg::*;
#(
  parameter int unsigned RadWidth  = RadW,
  parameter int unsigned SideWidth = SideW
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [RadWidth-1:0]       in_rad_i,
  input  logic [SideWidth-1:0]      in_side_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [RadWidth/2-1:0]     out_root_o,
  output logic [SideWidth-1:0]      out_side_o
);

  localparam int unsigned QW   = RadWidth / 2;
  localparam int unsigned RemW = QW + 2;

  logic                 v_q    [QW];
  logic [RemW-1:0]      rem_q  [QW];
  logic [QW-1:0]        root_q [QW];
  logic [RadWidth-1:0]  rad_q  [QW];
  logic [SideWidth-1:0] side_q [QW];
  logic                 rdy    [QW+1];

  assign rdy[QW] = out_ready_i;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic                 v_in;
    logic [RemW-1:0]      rem_in;
    logic [QW-1:0]        root_in;
    logic [RadWidth-1:0]  rad_in;
    logic [SideWidth-1:0] side_in;
    logic [RemW:0]        cur;
    logic [RemW:0]        trial;
    logic                 ge;

    if (k == 0) begin : g_first
      assign v_in    = in_valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = in_rad_i;
      assign side_in = in_side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign side_in = side_q[k-1];
    end

    // remainder stays below 2^(QW+1), so its top bit is always zero
    assign cur   = {rem_in[RemW-2:0], rad_in[RadWidth-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = (cur >= trial);
    assign rdy[k] = !v_q[k] || rdy[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && v_in) begin
        rem_q[k]  <= ge ? RemW'(cur - trial) : RemW'(cur);
        root_q[k] <= {root_in[QW-2:0], ge};
        rad_q[k]  <= {rad_in[RadWidth-3:0], 2'b00};
        side_q[k] <= side_in;
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[QW-1];
  assign out_root_o  = root_q[QW-1];
  assign out_side_o  = side_q[QW-1];

endmodule

>>> src/pair_association_score_core.sv
// ----------------------------------------------------------------------------
// pair_association_score_core: distance and type score of one object pair
// Euclidean distance gap scaled by 2.5 and by a subkind/kind probability.
// ----------------------------------------------------------------------------
// Pipeline: input transaction to result valid passes 5 front stages,
//   25 square-root stages and 4 tail stages.
// Throughput: one pair per cycle without stalls; each stage is a register
//   with its own valid bit and a ready chain; bubbles close up under stalls.
// Reset: rst_ni clears all valid bits and loads register reset values.
module pair_association_score_core
  import pas_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // config write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  // pair input
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // tdata, low bit up: first_x[24] first_y[24] second_x[24] second_y[24]
  //   first_kind[4] second_kind[4] first_subkind[5] second_subkind[5]
  //   first_prob[17] second_prob[17], zero fill to 152
  input  logic [151:0]       s_axis_tdata,
  // score output
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // tdata: pair_score[32]
  output logic [31:0]        m_axis_tdata
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [LimitW-1:0] limit_q;
  logic [ScoreW-1:0] min_q;
  logic              tce_q;
  logic [ScaleW-1:0] scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitRst;
      min_q   <= MinRst;
      tce_q   <= TceRst;
      scale_q <= ScaleRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LIMIT: limit_q <= cfg_data_i[LimitW-1:0];
        CFG_MIN:   min_q   <= cfg_data_i[ScoreW-1:0];
        CFG_TCE:   tce_q   <= cfg_data_i[0];
        CFG_SCALE: scale_q <= cfg_data_i[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input unpack
  // --------------------------------------------------------------------------
  logic signed [PosW-1:0] fx, fy, sx, sy;
  logic [KindW-1:0]       fk, sk;
  logic [SubW-1:0]        fs, ss;
  logic [ProbW-1:0]       fp, sp;

  assign fx = s_axis_tdata[23:0];
  assign fy = s_axis_tdata[47:24];
  assign sx = s_axis_tdata[71:48];
  assign sy = s_axis_tdata[95:72];
  assign fk = s_axis_tdata[99:96];
  assign sk = s_axis_tdata[103:100];
  assign fs = s_axis_tdata[108:104];
  assign ss = s_axis_tdata[113:109];
  assign fp = s_axis_tdata[130:114];
  assign sp = s_axis_tdata[147:131];

  // --------------------------------------------------------------------------
  // Stage payloads
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic [PosW-1:0]  ax;
    logic [PosW-1:0]  ay;
    logic [ProbW-1:0] p1;
    logic [ProbW-1:0] p2;
    logic [ProbW-1:0] q1;   // one minus p1
    logic [ProbW-1:0] q2;
    logic             sub_eq;
    logic             kind_ok;
  } st_a_t;

  typedef struct packed {
    logic [2*PosW-1:0]  sqx;
    logic [2*PosW-1:0]  sqy;
    logic [2*ProbW-1:0] qq;
    logic [2*ProbW-1:0] m1;
    logic [2*ProbW-1:0] m2;
    logic               sub_eq;
    logic               kind_ok;
  } st_b_t;

  typedef struct packed {
    logic [2*PosW:0]    sum;
    logic [FactW-1:0]   same;
    logic [FactW-1:0]   mix;
    logic               sub_eq;
    logic               kind_ok;
  } st_c_t;

  typedef struct packed {
    logic [2*PosW:0]    sum;
    logic [FactW-1:0]   same;
    logic [FactW-1:0]   mh;     // mix high part times scale
    logic [31:0]        ml;     // mix low part times scale
    logic               sub_eq;
    logic               kind_ok;
  } st_d_t;

  typedef struct packed {
    logic [2*PosW:0]    sum;
    logic [FactW-1:0]   fact;
    logic               sh33;   // 1: shift by 33, 0: shift by 25
  } st_e_t;

  typedef struct packed {
    logic [22:0]        raw;    // 2.5 * gap in Q.9
    logic [FactW-1:0]   fact;
    logic               sh33;
  } st_g_t;

  typedef struct packed {
    logic [39:0]        pa;
    logic [38:0]        pb;
    logic               sh33;
  } st_h_t;

  logic  v_a_q, v_b_q, v_c_q, v_d_q, v_e_q, v_g_q, v_h_q, v_i_q, v_j_q;
  logic  rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_g, rdy_h, rdy_i, rdy_j;
  st_a_t a_d, a_q;
  st_b_t b_d, b_q;
  st_c_t c_d, c_q;
  st_d_t d_d, d_q;
  st_e_t e_d, e_q;
  st_g_t g_d, g_q;
  st_h_t h_d, h_q;
  logic [30:0] i_d, i_q;
  logic [ScoreW-1:0] j_d, j_q;

  logic              sq_in_ready, sq_out_valid;
  logic [RootW-1:0]  sq_root;
  logic [SideW-1:0]  sq_side;
  st_e_t             sq_e;

  // ready chain: a stage takes new data when empty or when it drains
  assign rdy_j = !v_j_q || m_axis_tready;
  assign rdy_i = !v_i_q || rdy_j;
  assign rdy_h = !v_h_q || rdy_i;
  assign rdy_g = !v_g_q || rdy_h;
  assign rdy_e = !v_e_q || sq_in_ready;
  assign rdy_d = !v_d_q || rdy_e;
  assign rdy_c = !v_c_q || rdy_d;
  assign rdy_b = !v_b_q || rdy_c;
  assign rdy_a = !v_a_q || rdy_b;
  assign s_axis_tready = rdy_a;

  // --------------------------------------------------------------------------
  // Stage A: absolute differences, clamped probabilities, code compares
  // --------------------------------------------------------------------------
  always_comb begin
    logic signed [PosW:0] dx, dy;
    logic [ProbW-1:0]     c1, c2;
    dx = $signed({fx[PosW-1], fx}) - $signed({sx[PosW-1], sx});
    dy = $signed({fy[PosW-1], fy}) - $signed({sy[PosW-1], sy});
    c1 = (fp > ProbOne) ? ProbOne : fp;
    c2 = (sp > ProbOne) ? ProbOne : sp;
    a_d.ax      = dx[PosW] ? PosW'(-dx) : dx[PosW-1:0];
    a_d.ay      = dy[PosW] ? PosW'(-dy) : dy[PosW-1:0];
    a_d.p1      = c1;
    a_d.p2      = c2;
    a_d.q1      = ProbOne - c1;
    a_d.q2      = ProbOne - c2;
    a_d.sub_eq  = (fs == ss);
    a_d.kind_ok = (fk == sk) || (fk == '0) || (sk == '0);
  end

  // Stage B: squares and probability products
  always_comb begin
    b_d.sqx     = a_q.ax * a_q.ax;
    b_d.sqy     = a_q.ay * a_q.ay;
    b_d.qq      = a_q.q1 * a_q.q2;
    b_d.m1      = a_q.q1 * a_q.p2;
    b_d.m2      = a_q.q2 * a_q.p1;
    b_d.sub_eq  = a_q.sub_eq;
    b_d.kind_ok = a_q.kind_ok;
  end

  // Stage C: sum of squares, same-subkind and mixed probabilities
  always_comb begin
    logic [2*ProbW-1:0] same_w, mix_w;
    same_w      = (2*ProbW)'(1) << 32;
    same_w      = same_w - b_q.qq;
    mix_w       = b_q.m1 + b_q.m2;   // at most 2^32
    c_d.sum     = {1'b0, b_q.sqx} + {1'b0, b_q.sqy};
    c_d.same    = same_w[FactW-1:0];
    c_d.mix     = mix_w[FactW-1:0];
    c_d.sub_eq  = b_q.sub_eq;
    c_d.kind_ok = b_q.kind_ok;
  end

  // Stage D: mix times scale, split into two partial products
  always_comb begin
    d_d.sum     = c_q.sum;
    d_d.same    = c_q.same;
    d_d.mh      = c_q.mix[FactW-1:16] * scale_q;
    d_d.ml      = c_q.mix[15:0] * scale_q;
    d_d.sub_eq  = c_q.sub_eq;
    d_d.kind_ok = c_q.kind_ok;
  end

  // Stage E: pick the factor; type check off acts as factor one in Q0.32
  always_comb begin
    logic [FactW-1:0] fmix;
    fmix    = d_q.mh + {{(FactW-16){1'b0}}, d_q.ml[31:16]};
    e_d.sum = d_q.sum;
    if (!tce_q) begin
      e_d.fact = FactW'(1) << 32;
      e_d.sh33 = 1'b1;
    end else if (d_q.sub_eq) begin
      e_d.fact = d_q.same;
      e_d.sh33 = 1'b1;
    end else if (d_q.kind_ok) begin
      e_d.fact = fmix;
      e_d.sh33 = 1'b0;
    end else begin
      e_d.fact = '0;
      e_d.sh33 = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
      v_c_q <= 1'b0;
      v_d_q <= 1'b0;
      v_e_q <= 1'b0;
      v_g_q <= 1'b0;
      v_h_q <= 1'b0;
      v_i_q <= 1'b0;
      v_j_q <= 1'b0;
    end else begin
      if (rdy_a) v_a_q <= s_axis_tvalid;
      if (rdy_b) v_b_q <= v_a_q;
      if (rdy_c) v_c_q <= v_b_q;
      if (rdy_d) v_d_q <= v_c_q;
      if (rdy_e) v_e_q <= v_d_q;
      if (rdy_g) v_g_q <= sq_out_valid;
      if (rdy_h) v_h_q <= v_g_q;
      if (rdy_i) v_i_q <= v_h_q;
      if (rdy_j) v_j_q <= v_i_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && s_axis_tvalid) a_q <= a_d;
    if (rdy_b && v_a_q)         b_q <= b_d;
    if (rdy_c && v_b_q)         c_q <= c_d;
    if (rdy_d && v_c_q)         d_q <= d_d;
    if (rdy_e && v_d_q)         e_q <= e_d;
    if (rdy_g && sq_out_valid)  g_q <= g_d;
    if (rdy_h && v_g_q)         h_q <= h_d;
    if (rdy_i && v_h_q)         i_q <= i_d;
    if (rdy_j && v_i_q)         j_q <= j_d;
  end

  // --------------------------------------------------------------------------
  // Distance: floor(sqrt(dx^2 + dy^2)) in Q.8
  // --------------------------------------------------------------------------
  pas_isqrt #(
    .RadWidth  (RadW),
    .SideWidth (SideW)
  ) u_isqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v_e_q),
    .in_ready_o  (sq_in_ready),
    .in_rad_i    ({{(RadW-2*PosW-1){1'b0}}, e_q.sum}),
    .in_side_i   ({e_q.fact, e_q.sh33}),
    .out_valid_o (sq_out_valid),
    .out_ready_i (rdy_g),
    .out_root_o  (sq_root),
    .out_side_o  (sq_side)
  );

  assign sq_e.sum  = '0;
  assign sq_e.fact = sq_side[SideW-1:1];
  assign sq_e.sh33 = sq_side[0];

  // Stage G: gap to the limit, times five
  always_comb begin
    logic [RootW-1:0]  lim_w;
    logic [LimitW-1:0] gap;
    lim_w    = {{(RootW-LimitW){1'b0}}, limit_q};
    gap      = (lim_w > sq_root) ? LimitW'(lim_w - sq_root) : '0;
    g_d.raw  = {3'b000, gap} + {1'b0, gap, 2'b00};
    g_d.fact = sq_e.fact;
    g_d.sh33 = sq_e.sh33;
  end

  // Stage H: raw times factor as two partial products
  always_comb begin
    h_d.pa   = g_q.raw * g_q.fact[FactW-1:16];
    h_d.pb   = g_q.raw * g_q.fact[15:0];
    h_d.sh33 = g_q.sh33;
  end

  // Stage I: recombine and scale; the result stays below 2^31, no saturation
  always_comb begin
    logic [55:0] full;
    full = {h_q.pa[39:0], 16'h0000} + {17'h0, h_q.pb};
    i_d  = h_q.sh33 ? {8'h00, full[55:33]} : full[55:25];
  end

  // Stage J: minimum score threshold
  assign j_d = ({1'b0, i_q} < min_q) ? '0 : {1'b0, i_q};

  assign m_axis_tvalid = v_j_q;
  assign m_axis_tdata  = j_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_tce_off_unity : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rdy_e && v_d_q && !tce_q) |=> (e_q.fact == (FactW'(1) << 32)) && e_q.sh33)
    else $error("factor not one with type check off");

  a_gap_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_g_q |-> (g_q.raw <= ({3'b000, limit_q} + {1'b0, limit_q, 2'b00})))
    else $error("raw score above five times limit");

  a_accept_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> v_a_q)
    else $error("accepted transaction not captured");

  a_mix_shift : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_e_q && !e_q.sh33) |-> (e_q.fact < (FactW'(1) << 32)))
    else $error("mixed factor out of range");

endmodule
